### rtl/core/frt_pkg.sv
// Shared types and constants for the fragment reassembly tracker.
// Holds the header and result word layouts, status codes and table-update controls.
// No dependencies.
package frt_pkg;

    localparam int TAG_COUNT_DEF   = 256;
    localparam int LENGTH_BITS_DEF = 16;

    localparam int MSG_W  = 9;
    localparam int EID_W  = 16;
    localparam int NPT_W  = 33;
    localparam int TAG_W  = 8;
    localparam int SEQ_W  = 7;
    localparam int STAT_W = 3;
    localparam int TOT_W  = 16;

    // Smallest message that still carries a full fragment header
    localparam logic [MSG_W-1:0] MIN_MSG = MSG_W'(16);

    typedef logic [STAT_W-1:0] status_t;

    localparam status_t ST_SHORT   = 3'd0;
    localparam status_t ST_START   = 3'd1;
    localparam status_t ST_APPEND  = 3'd2;
    localparam status_t ST_DONE    = 3'd3;
    localparam status_t ST_ORDER   = 3'd4;
    localparam status_t ST_NOSTART = 3'd5;

    typedef struct packed {
        logic [MSG_W-1:0] msg_size;
        logic [EID_W-1:0] event_id;
        logic [NPT_W-1:0] npt;
        logic [TAG_W-1:0] command_tag;
        logic [SEQ_W-1:0] sequence_number;
        logic             more_follows;
    } frt_in_t;

    typedef struct packed {
        status_t          status;
        logic             discarded_incomplete;
        logic [TAG_W-1:0] tag_out;
        logic [EID_W-1:0] event_id_out;
        logic [NPT_W-1:0] npt_out;
        logic [TOT_W-1:0] total_length;
        logic             length_saturated;
    } frt_out_t;

    // Table update requested by the decision logic
    typedef struct packed {
        logic mem_we;
        logic valid_set;
        logic valid_clr;
    } upd_ctl_t;

endpackage

### rtl/core/frt_entry_mem.sv
// Entry memory of the fragment reassembly tracker: one write port, one read port.
// Read data is registered. Contents are undefined until written.
// Depends on nothing.
module frt_entry_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 72
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/frt_update.sv
// Decision logic of the fragment reassembly tracker: classifies one header against
// its table entry and forms the new entry, the table controls and the result word.
// Depends on frt_pkg.
module frt_update #(
    parameter int LENGTH_BITS = frt_pkg::LENGTH_BITS_DEF
) (
    input  frt_pkg::frt_in_t              hdr,
    input  logic                          ent_valid,
    input  logic [frt_pkg::SEQ_W-1:0]     ent_seq,
    input  logic [LENGTH_BITS-1:0]        ent_total,
    input  logic [frt_pkg::EID_W-1:0]     ent_eid,
    input  logic [frt_pkg::NPT_W-1:0]     ent_npt,
    output logic [frt_pkg::SEQ_W-1:0]     new_seq,
    output logic [LENGTH_BITS-1:0]        new_total,
    output logic [frt_pkg::EID_W-1:0]     new_eid,
    output logic [frt_pkg::NPT_W-1:0]     new_npt,
    output frt_pkg::upd_ctl_t             ctl,
    output frt_pkg::frt_out_t             res
);

    import frt_pkg::*;

    localparam int SUM_W = ((LENGTH_BITS > MSG_W) ? LENGTH_BITS : MSG_W) + 1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    logic                   too_short;
    logic [MSG_W-1:0]       dlen;
    logic [LENGTH_BITS-1:0] base;
    logic [SUM_W-1:0]       sum;
    logic [31:0]            total_wide;
    logic                   in_order;
    logic                   show;

    assign too_short  = hdr.msg_size < MIN_MSG;
    assign dlen       = hdr.msg_size - MIN_MSG;
    assign in_order   = ({1'b0, ent_seq} + (SEQ_W + 1)'(1)) == {1'b0, hdr.sequence_number};

    // A start counts from zero, an append from the stored total
    assign base = (hdr.sequence_number == '0) ? '0 : ent_total;
    assign sum  = SUM_W'(base) + SUM_W'(dlen);

    always_comb
    begin
        new_eid   = ent_eid;
        new_npt   = ent_npt;
        new_seq   = hdr.sequence_number;
        new_total = (sum > SUM_W'(LEN_MAX)) ? LEN_MAX : sum[LENGTH_BITS-1:0];
        ctl       = '0;
        res       = '0;
        show      = 1'b0;
        res.tag_out = hdr.command_tag;

        if (too_short)
        begin
            res.status = ST_SHORT;
        end
        else if (hdr.sequence_number != '0)
        begin
            if (!ent_valid)
            begin
                res.status = ST_NOSTART;
            end
            else if (!in_order)
            begin
                // drop the open entry
                res.status    = ST_ORDER;
                ctl.valid_clr = 1'b1;
            end
            else
            begin
                res.status = ST_APPEND;
                ctl.mem_we = 1'b1;
                show       = 1'b1;
            end
        end
        else
        begin
            res.status               = ST_START;
            res.discarded_incomplete = ent_valid;
            new_eid                  = hdr.event_id;
            new_npt                  = hdr.npt;
            ctl.mem_we               = 1'b1;
            ctl.valid_set            = 1'b1;
            show                     = 1'b1;
        end

        // last fragment: report and free the entry
        if (show && !hdr.more_follows)
        begin
            res.status    = ST_DONE;
            ctl.valid_set = 1'b0;
            ctl.valid_clr = 1'b1;
        end

        if (show)
        begin
            res.event_id_out     = new_eid;
            res.npt_out          = new_npt;
            res.total_length     = total_wide[TOT_W-1:0];
            res.length_saturated = new_total == LEN_MAX;
        end
    end

    assign total_wide = 32'(new_total);

endmodule

### rtl/core/fragment_reassembly_tracker.sv
// Top level of the fragment reassembly tracker.
// Pipeline registers, per-tag valid bits and write forwarding around the entry memory.
// Depends on frt_pkg, frt_entry_mem and frt_update.
//
// Usage:
//   Header words enter on hdr / hdr_valid / hdr_ready, one parsed fragment
//   header per word. Result words leave on res / res_valid / res_ready, one
//   result per header, in header order.
//   An accepted header is registered in the decision stage, then its result
//   in the output register. Throughput: one header per cycle when not stalled.
//   Each header does one read-modify-write of its table entry; the entry
//   memory read is issued at acceptance and the write happens as the header
//   leaves the decision stage. A header for the same tag right behind takes
//   the fresh entry from the forwarding register.
//   Reset clears all valid bits at once, so the table is empty right after
//   reset; no clearing pass is needed and headers are taken at once.
//   When the receiver stalls, the result register holds, the decision stage
//   holds one more header, and hdr_ready drops once both are full.
//   Tags at or above TAG_COUNT fold onto tag modulo TAG_COUNT.
module fragment_reassembly_tracker #(
    parameter int TAG_COUNT   = frt_pkg::TAG_COUNT_DEF,
    parameter int LENGTH_BITS = frt_pkg::LENGTH_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hdr_valid,
    output logic              hdr_ready,
    input  frt_pkg::frt_in_t  hdr,
    output logic              res_valid,
    input  logic              res_ready,
    output frt_pkg::frt_out_t res
);

    import frt_pkg::*;

    localparam int IDX_W   = $clog2(TAG_COUNT);
    localparam int ENT_W   = SEQ_W + EID_W + NPT_W + LENGTH_BITS;
    localparam int TAG_NUM = 1 << TAG_W;

    typedef logic [IDX_W-1:0] idx_lut_t [TAG_NUM];

    // Tag to table index, worked out at elaboration
    function automatic idx_lut_t build_idx_lut();
        idx_lut_t lut;
        for (int i = 0; i < TAG_NUM; i++)
        begin
            lut[i] = IDX_W'(i % TAG_COUNT);
        end
        return lut;
    endfunction

    localparam idx_lut_t IDX_LUT = build_idx_lut();

    logic                   accept;
    logic                   s1_adv;
    logic [IDX_W-1:0]       hdr_idx;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    frt_in_t                s1_hdr_reg;
    logic [IDX_W-1:0]       s1_idx_reg;

    logic                   fwd_hit_reg;
    logic                   fwd_hit_next;
    logic [ENT_W-1:0]       fwd_ent_reg;

    logic [TAG_COUNT-1:0]   valid_reg;
    logic [TAG_COUNT-1:0]   valid_next;

    logic                   res_valid_reg;
    logic                   res_valid_next;
    frt_out_t               res_reg;

    logic [ENT_W-1:0]       rd_ent;
    logic [ENT_W-1:0]       cur_ent;
    logic [ENT_W-1:0]       wr_ent;

    logic [SEQ_W-1:0]       new_seq;
    logic [LENGTH_BITS-1:0] new_total;
    logic [EID_W-1:0]       new_eid;
    logic [NPT_W-1:0]       new_npt;
    upd_ctl_t               ctl;
    frt_out_t               upd_res;
    logic                   mem_we;

    // Advance the decision stage whenever the result register is free or draining
    assign s1_adv    = s1_valid_reg && (!res_valid_reg || res_ready);
    assign hdr_ready = !s1_valid_reg || !res_valid_reg || res_ready;
    assign accept    = hdr_valid && hdr_ready;
    assign hdr_idx   = IDX_LUT[hdr.command_tag];
    assign mem_we    = s1_adv && ctl.mem_we;

    // Entry as seen by the decision stage: forwarded write or memory read data
    assign cur_ent = fwd_hit_reg ? fwd_ent_reg : rd_ent;
    assign wr_ent  = {new_seq, new_eid, new_npt, new_total};

    frt_entry_mem #(
        .DEPTH (TAG_COUNT),
        .WIDTH (ENT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (s1_idx_reg),
        .wr_data (wr_ent),
        .rd_en   (accept),
        .rd_addr (hdr_idx),
        .rd_data (rd_ent)
    );

    frt_update #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_upd (
        .hdr       (s1_hdr_reg),
        .ent_valid (valid_reg[s1_idx_reg]),
        .ent_seq   (cur_ent[ENT_W-1 -: SEQ_W]),
        .ent_eid   (cur_ent[ENT_W-SEQ_W-1 -: EID_W]),
        .ent_npt   (cur_ent[LENGTH_BITS +: NPT_W]),
        .ent_total (cur_ent[LENGTH_BITS-1:0]),
        .new_seq   (new_seq),
        .new_total (new_total),
        .new_eid   (new_eid),
        .new_npt   (new_npt),
        .ctl       (ctl),
        .res       (upd_res)
    );

    // Control next-state
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (s1_adv)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end

        // The memory write lands on the same edge as this read; bypass it
        fwd_hit_next = accept && mem_we && (s1_idx_reg == hdr_idx);

        valid_next = valid_reg;
        if (s1_adv && ctl.valid_set)
        begin
            valid_next[s1_idx_reg] = 1'b1;
        end
        if (s1_adv && ctl.valid_clr)
        begin
            valid_next[s1_idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            valid_reg     <= valid_next;
            if (accept)
            begin
                fwd_hit_reg <= fwd_hit_next;
            end
        end
    end

    // Payload registers: hold unless loaded
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hdr_reg  <= hdr;
            s1_idx_reg  <= hdr_idx;
            fwd_ent_reg <= wr_ent;
        end
        if (s1_adv)
        begin
            res_reg <= upd_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### tb/tb_fragment_reassembly_tracker.sv
// Self-checking testbench for fragment_reassembly_tracker: directed and random header traffic.
// Predicts each result word from its own per-tag table and checks every field in order.
// Depends on frt_pkg and the fragment_reassembly_tracker RTL.
module tb_fragment_reassembly_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    import frt_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam logic [TOT_W-1:0] BYTE_LIMIT = TOT_W'((64'd1 << LENGTH_BITS_DEF) - 1);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Block inputs start known; everything after time zero is driven at the rising edge
    logic     hdr_valid = 1'b0;
    logic     res_ready = 1'b0;
    frt_in_t  hdr = '0;
    logic     hdr_ready;
    logic     res_valid;
    frt_out_t res;

    // Idle rates in percent of cycles, changed per phase by the stimulus thread
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // Long receiver hold-off: the stimulus thread bumps the request count,
    // the receiver process counts the stall out on its own
    int rx_hold_requests = 0;
    int rx_holds_served  = 0;
    int rx_hold_left     = 0;

    int errors      = 0;
    int cycle_count = 0;

    // Our copy of the per-tag reassembly table
    logic             tag_open     [TAG_COUNT_DEF];
    logic [SEQ_W-1:0] tag_last_seq [TAG_COUNT_DEF];
    logic [EID_W-1:0] tag_event_id [TAG_COUNT_DEF];
    logic [NPT_W-1:0] tag_npt      [TAG_COUNT_DEF];
    logic [TOT_W-1:0] tag_bytes    [TAG_COUNT_DEF];

    // Results still owed by the block, oldest first
    frt_out_t pending_results[$];
    frt_out_t want_res;

    fragment_reassembly_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr       (hdr),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: a correct run finishes far below this
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL fragment_reassembly_tracker");
            $finish;
        end
    end

    // Receiver: either serve a long hold-off or stall at random
    always @(posedge clk)
    begin
        if (rx_holds_served != rx_hold_requests)
        begin
            rx_holds_served <= rx_hold_requests;
            rx_hold_left    <= RX_HOLD_CYCLES;
            res_ready       <= 1'b0;
        end
        else if (rx_hold_left > 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            res_ready    <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Work out the result of one accepted header and advance the table.
    // Too short leaves the table alone; a nonzero sequence needs an open entry
    // and the directly following number, anything else frees or ignores it.
    function automatic frt_out_t track_fragment(input frt_in_t h);
        frt_out_t         r;
        int               idx;
        logic [MSG_W-1:0] data_len;
        logic [TOT_W:0]   sum;
        r = '0;
        r.tag_out = h.command_tag;
        idx = int'(h.command_tag) % TAG_COUNT_DEF;
        if (h.msg_size < MIN_MSG)
        begin
            r.status = ST_SHORT;
            return r;
        end
        data_len = h.msg_size - MIN_MSG;
        if (h.sequence_number != '0)
        begin
            if (!tag_open[idx])
            begin
                r.status = ST_NOSTART;
                return r;
            end
            if (int'(tag_last_seq[idx]) + 1 != int'(h.sequence_number))
            begin
                tag_open[idx] = 1'b0;
                r.status = ST_ORDER;
                return r;
            end
            sum = (TOT_W+1)'(tag_bytes[idx]) + (TOT_W+1)'(data_len);
            tag_last_seq[idx] = h.sequence_number;
            r.status = ST_APPEND;
        end
        else
        begin
            // a start replaces whatever was open on this tag
            r.discarded_incomplete = tag_open[idx];
            tag_open[idx]     = 1'b1;
            tag_last_seq[idx] = '0;
            tag_event_id[idx] = h.event_id;
            tag_npt[idx]      = h.npt;
            sum = (TOT_W+1)'(data_len);
            r.status = ST_START;
        end
        tag_bytes[idx] = (sum > (TOT_W+1)'(BYTE_LIMIT)) ? BYTE_LIMIT : sum[TOT_W-1:0];
        if (!h.more_follows)
        begin
            tag_open[idx] = 1'b0;
            r.status = ST_DONE;
        end
        r.event_id_out     = tag_event_id[idx];
        r.npt_out          = tag_npt[idx];
        r.total_length     = tag_bytes[idx];
        r.length_saturated = (tag_bytes[idx] == BYTE_LIMIT);
        return r;
    endfunction

    function automatic frt_in_t frag(input int size, input logic [EID_W-1:0] eid,
                                     input logic [NPT_W-1:0] npt, input int tag,
                                     input int seq, input logic more);
        frt_in_t h;
        h.msg_size        = MSG_W'(size);
        h.event_id        = eid;
        h.npt             = npt;
        h.command_tag     = TAG_W'(tag);
        h.sequence_number = SEQ_W'(seq);
        h.more_follows    = more;
        return h;
    endfunction

    // Mostly well-formed commands on a few busy tags, so entries live long and
    // same-tag headers run back to back; the rest is short words, restarts and noise.
    function automatic frt_in_t random_fragment();
        frt_in_t h;
        int      roll;
        int      size_roll;
        int      tag;
        roll      = $urandom_range(99);
        size_roll = $urandom_range(99);
        tag = ($urandom_range(99) < 60) ? $urandom_range(3) : $urandom_range(255);
        h.event_id     = EID_W'($urandom());
        h.npt          = {1'($urandom()), 32'($urandom())};
        h.command_tag  = TAG_W'(tag);
        h.more_follows = ($urandom_range(99) < 75);
        if (size_roll < 10)
            h.msg_size = MSG_W'(16);
        else if (size_roll < 20)
            h.msg_size = '1;
        else
            h.msg_size = MSG_W'($urandom_range(16, 511));
        if (roll < 5)
        begin
            h.msg_size        = MSG_W'($urandom_range(15));
            h.sequence_number = SEQ_W'($urandom());
        end
        else if (roll < 80)
        begin
            if (tag_open[tag] && tag_last_seq[tag] != '1)
                h.sequence_number = tag_last_seq[tag] + 1'b1;
            else
                h.sequence_number = '0;
        end
        else if (roll < 90)
            h.sequence_number = '0;
        else
            h.sequence_number = SEQ_W'($urandom());
        return h;
    endfunction

    // Offer one header word, idling first at the current rate, and hold it until taken
    task automatic send_header(input frt_in_t h);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            hdr_valid <= 1'b0;
            @(posedge clk);
        end
        hdr       <= h;
        hdr_valid <= 1'b1;
        @(posedge clk);
        while (!hdr_ready)
            @(posedge clk);
        pending_results.push_back(track_fragment(h));
    endtask

    // Drop valid and hold off until every owed result has come back
    task automatic wait_drained();
        hdr_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Compare every accepted result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none actual %h", $time, res);
            end
            else
            begin
                want_res = pending_results.pop_front();
                check_field("status", want_res.status, res.status);
                check_field("discarded_incomplete", want_res.discarded_incomplete,
                            res.discarded_incomplete);
                check_field("tag_out", want_res.tag_out, res.tag_out);
                check_field("event_id_out", want_res.event_id_out, res.event_id_out);
                check_field("npt_out", want_res.npt_out, res.npt_out);
                check_field("total_length", want_res.total_length, res.total_length);
                check_field("length_saturated", want_res.length_saturated,
                            res.length_saturated);
            end
        end
    end

    // Short messages never touch the table, whatever their sequence and tag
    task automatic test_short_messages();
        send_header(frag(0, '1, '1, 3, 0, 1'b1));
        send_header(frag(15, '0, '0, 3, 127, 1'b0));
    endtask

    task automatic test_missing_start();
        send_header(frag(100, 16'h1234, 33'h5, 10, 5, 1'b1));
    endtask

    // Full command at the field extremes: empty first fragment, two maximal ones,
    // then a straggler after completion that finds no entry
    task automatic test_full_command_extremes();
        send_header(frag(16, '1, '1, 255, 0, 1'b1));
        send_header(frag(511, '0, '0, 255, 1, 1'b1));
        send_header(frag(511, 16'h00ff, 33'h0_0000_0001, 255, 2, 1'b0));
        send_header(frag(200, '1, '1, 255, 3, 1'b1));
    endtask

    // A gap frees the entry; the follow-up then has no start. Later fragments
    // must report the first fragment's event id and time, not their own.
    task automatic test_out_of_order();
        send_header(frag(40, 16'hbeef, 33'h1_2345_6789, 7, 0, 1'b1));
        send_header(frag(40, 16'h0001, 33'h0_0000_0002, 7, 3, 1'b1));
        send_header(frag(40, 16'h0001, 33'h0_0000_0002, 7, 1, 1'b1));
        send_header(frag(60, 16'hcafe, 33'h0_8000_0000, 7, 0, 1'b1));
        send_header(frag(77, 16'h5555, 33'h1_0000_0000, 7, 1, 1'b1));
    endtask

    task automatic test_start_and_final();
        send_header(frag(511, '0, '0, 0, 0, 1'b0));
    endtask

    // Restart over an open entry, then a one-fragment command over an open entry
    task automatic test_replaced_entry();
        send_header(frag(30, 16'h0a0a, 33'h0_0000_1000, 20, 0, 1'b1));
        send_header(frag(31, 16'h0b0b, 33'h0_0000_2000, 20, 0, 1'b1));
        send_header(frag(32, 16'h0c0c, 33'h0_0000_3000, 20, 0, 1'b0));
        send_header(frag(33, 16'h0d0d, 33'h0_0000_4000, 20, 0, 1'b0));
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count)
            send_header(random_fragment());
        wait_drained();
    endtask

    // Stall the receiver for a long stretch while headers keep coming, so the
    // block fills and drops hdr_ready; then pause until everything is back
    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_requests <= rx_hold_requests + 1;
        repeat (40)
            send_header(random_fragment());
        wait_drained();
    endtask

    // The longest command the sequence field allows, mostly maximal fragments,
    // ending in a fragment that cannot follow sequence 127
    task automatic test_longest_command();
        int tag;
        int size;
        tag = $urandom_range(255);
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        for (int seq = 0; seq < 128; seq++)
        begin
            size = ($urandom_range(99) < 80) ? 511 : $urandom_range(16, 511);
            send_header(frag(size, EID_W'($urandom()), {1'($urandom()), 32'($urandom())},
                             tag, seq, 1'b1));
        end
        send_header(frag(300, '0, '0, tag, $urandom_range(1, 127), 1'b1));
        wait_drained();
    endtask

    initial
    begin
        $timeformat(-9, 0, " ns", 0);
        for (int i = 0; i < TAG_COUNT_DEF; i++)
        begin
            tag_open[i]     = 1'b0;
            tag_last_seq[i] = '0;
            tag_event_id[i] = '0;
            tag_npt[i]      = '0;
            tag_bytes[i]    = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_short_messages();
        test_missing_start();
        test_full_command_extremes();
        test_out_of_order();
        test_start_and_final();
        test_replaced_entry();
        wait_drained();

        test_random_traffic(18, 72, 260);
        test_random_traffic(72, 18, 260);
        test_random_traffic(0, 0, 260);
        test_output_backpressure();
        test_longest_command();

        // Let any stray word surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("PASS fragment_reassembly_tracker");
        else
            $display("FAIL fragment_reassembly_tracker");
        $finish;
    end

endmodule
